FILE: hw/rtl/c3rb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3rb_pkg: shared types and constants of the 3x3 replicate-border convolver
// Field widths, register indexes, cell control and result record.
// ----------------------------------------------------------------------------
package c3rb_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 8;
	localparam int KERNEL_SIZE    = 3;
	localparam int COEF_BITS      = 16;
	localparam int KROW_BITS      = KERNEL_SIZE * COEF_BITS;
	localparam int LW_BITS        = 11;
	localparam int LW_RESET       = 1000;
	localparam int CONV_BITS      = 32;
	localparam int CFG_IDX_BITS   = 2;
	localparam int OUT_DEPTH      = 8;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_KROW0  = 2'd0,
		CFG_KROW1  = 2'd1,
		CFG_KROW2  = 2'd2,
		CFG_LWIDTH = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic en;
		logic fill;
	} cell_ctrl_t;

	typedef struct packed {
		logic [CONV_BITS-1:0] conv_value;
		logic                 end_of_line;
		logic                 end_of_frame;
		logic                 last_of_run;
	} res_t;

endpackage

FILE: hw/rtl/conv3x3_replicate_border_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_replicate_border_unit: streaming 3x3 convolution, replicate borders
// Raster pixels in, one 32-bit sum per pixel out, one row and column behind.
//
// channel   dir  fields
// s_axis    in   tdata: pixel_value; tuser: req_type
// m_axis    out  tdata: conv_value; tuser: end_of_line, end_of_frame;
//                tlast: last_of_run
// cfg       in   cfg_we, cfg_index, cfg_data (kernel rows, line width)
//
// One input transaction per cycle while tready is high; results leave at one
// per cycle while m_axis_tready is high; the second result at the end of a row
// uses the slot of the next row's first. A result is registered in the line store
// read, window column cells, product register and column sum register, then queued.
// tready follows a credit count of the eight-entry result queue only.
// No clearing pass after reset: line stores are written before being read.
// ----------------------------------------------------------------------------
module conv3x3_replicate_border_unit #(
	parameter int MAX_WIDTH  = c3rb_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = c3rb_pkg::PIXEL_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // pixel_value
	input  logic [0:0]                            s_axis_tuser,  // req_type
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [c3rb_pkg::CONV_BITS-1:0]        m_axis_tdata,  // conv_value
	output logic [1:0]                            m_axis_tuser,  // end_of_line, end_of_frame
	output logic                                  m_axis_tlast,
	input  logic                                  cfg_we,
	input  logic [c3rb_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [c3rb_pkg::KROW_BITS-1:0]        cfg_data
);

	import c3rb_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > LW_BITS) ? CW + 1 : LW_BITS;
	localparam int RW = $clog2(OUT_DEPTH + 1);
	localparam int K  = KERNEL_SIZE;

	// configuration
	logic [K-1:0][KROW_BITS-1:0] krow_q;
	logic [LW_BITS-1:0]          lwidth_q;

	// frame position
	logic [CW-1:0] col_q;
	logic [1:0]    rows_q;
	logic          flushing_q;
	logic [RW-1:0] res_q;

	logic [WW-1:0] lw_ext;
	logic [WW-1:0] w_eff;
	logic          in_acc;
	logic          req_flush;
	logic          flush_n;
	logic          first;
	logic          ignore;
	logic          last;
	logic [1:0]    n_res;
	logic          pop;

	// s1: line store read
	logic                  v_s1;
	logic                  first_s1;
	logic                  flush_s1;
	logic                  zero_s1;
	logic                  last_s1;
	logic                  eof_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [CW-1:0]         addr_s1;

	// result control down the cell pipeline
	logic ea_s2, eb_s2, lor_a_s2, eof_s2;
	logic ea_s3, eb_s3, lor_a_s3, eof_s3;
	logic ea_s4, eb_s4, lor_a_s4, eof_s4;

	logic                    ram_we;
	logic [2*PIXEL_BITS-1:0] ram_wdata;
	logic [2*PIXEL_BITS-1:0] ram_rdata;
	logic [PIXEL_BITS-1:0]   up_pix;
	logic [PIXEL_BITS-1:0]   mid_pix;

	logic [K-1:0][PIXEL_BITS-1:0] new_col;
	cell_ctrl_t                   cell_ctrl;
	logic [K-1:0][K-1:0][PIXEL_BITS-1:0] win_col;
	logic [K-1:0][K-1:0][COEF_BITS-1:0]  cell_coef;
	logic [CONV_BITS-1:0] cell_sum_a [K];
	logic [CONV_BITS-1:0] cell_sum_b [K];
	logic [CONV_BITS-1:0] total_a;
	logic [CONV_BITS-1:0] total_b;
	res_t                 res_a;
	res_t                 res_b;
	res_t                 res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			krow_q   <= '0;
			lwidth_q <= LW_BITS'(LW_RESET);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_KROW0:  krow_q[0] <= cfg_data;
				CFG_KROW1:  krow_q[1] <= cfg_data;
				CFG_KROW2:  krow_q[2] <= cfg_data;
				CFG_LWIDTH: lwidth_q  <= cfg_data[LW_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input side
	assign lw_ext = WW'(lwidth_q);
	assign w_eff  = (lw_ext < WW'(2)) ? WW'(2) :
	                (lw_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : lw_ext;

	assign s_axis_tready = (res_q <= RW'(OUT_DEPTH - 2));
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign req_flush     = s_axis_tuser[0] | flushing_q;
	assign flush_n       = req_flush | flushing_q;
	assign first         = (rows_q == 2'd0);
	assign ignore        = req_flush & first;
	assign last          = ((WW'(col_q) + WW'(1)) >= w_eff);
	assign n_res         = (first | ignore) ? 2'd0 :
	                       (2'((col_q != '0)) + 2'(last));
	assign pop           = m_axis_tvalid & m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			rows_q     <= '0;
			flushing_q <= 1'b0;
			res_q      <= '0;
			v_s1       <= 1'b0;
		end else begin
			res_q <= res_q + (in_acc ? RW'(n_res) : RW'(0)) - RW'(pop);
			v_s1  <= in_acc & ~ignore;
			if (in_acc && !ignore) begin
				if (first) begin
					if (last) begin
						col_q  <= '0;
						rows_q <= 2'd1;
					end else begin
						col_q <= col_q + CW'(1);
					end
				end else begin
					flushing_q <= flush_n;
					if (last) begin
						col_q <= '0;
						if (flush_n) begin
							rows_q     <= '0;
							flushing_q <= 1'b0;
						end else if (rows_q < 2'd2) begin
							rows_q <= rows_q + 2'd1;
						end
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			first_s1 <= first;
			flush_s1 <= req_flush;
			zero_s1  <= (col_q == '0);
			last_s1  <= last;
			eof_s1   <= last & flush_n;
			pix_s1   <= s_axis_tdata[PIXEL_BITS-1:0];
			addr_s1  <= col_q;
		end
	end

	// line stores: upper row in the high half, middle row in the low half
	assign up_pix    = ram_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
	assign mid_pix   = ram_rdata[PIXEL_BITS-1:0];
	assign ram_we    = v_s1 & (first_s1 | ~flush_s1);
	assign ram_wdata = first_s1 ? {pix_s1, pix_s1} : {mid_pix, pix_s1};

	c3rb_ram #(
		.WIDTH(2 * PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s1),
		.wdata(ram_wdata),
		.re   (in_acc),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	// window column cells
	assign new_col[0]     = up_pix;
	assign new_col[1]     = mid_pix;
	assign new_col[2]     = flush_s1 ? mid_pix : pix_s1;
	assign cell_ctrl.en   = v_s1 & ~first_s1;
	assign cell_ctrl.fill = zero_s1;

	for (genvar j = 0; j < K; j++) begin : g_cell
		logic [K-1:0][PIXEL_BITS-1:0] shift_src;
		logic [K-1:0][PIXEL_BITS-1:0] nb_src;

		for (genvar r = 0; r < K; r++) begin : g_coef
			assign cell_coef[j][r] = krow_q[r][COEF_BITS*j +: COEF_BITS];
		end

		if (j == K - 1) begin : g_edge
			assign shift_src = new_col;
			assign nb_src    = win_col[j];
		end else begin : g_mid
			assign shift_src = win_col[j+1];
			assign nb_src    = win_col[j+1];
		end

		c3rb_cell #(
			.PIXEL_BITS(PIXEL_BITS)
		) u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl),
			.fill_col (new_col),
			.shift_col(shift_src),
			.nb_col   (nb_src),
			.coef     (cell_coef[j]),
			.col      (win_col[j]),
			.sum_a    (cell_sum_a[j]),
			.sum_b    (cell_sum_b[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ea_s2 <= 1'b0;
			eb_s2 <= 1'b0;
			ea_s3 <= 1'b0;
			eb_s3 <= 1'b0;
			ea_s4 <= 1'b0;
			eb_s4 <= 1'b0;
		end else begin
			ea_s2 <= cell_ctrl.en & ~zero_s1;
			eb_s2 <= cell_ctrl.en & last_s1;
			ea_s3 <= ea_s2;
			eb_s3 <= eb_s2;
			ea_s4 <= ea_s3;
			eb_s4 <= eb_s3;
		end
	end

	always_ff @(posedge clk) begin
		lor_a_s2 <= ~last_s1;
		eof_s2   <= eof_s1;
		lor_a_s3 <= lor_a_s2;
		eof_s3   <= eof_s2;
		lor_a_s4 <= lor_a_s3;
		eof_s4   <= eof_s3;
	end

	always_comb begin
		total_a = '0;
		total_b = '0;
		for (int j = 0; j < K; j++) begin
			total_a = total_a + cell_sum_a[j];
			total_b = total_b + cell_sum_b[j];
		end
	end

	assign res_a = '{conv_value: total_a, end_of_line: 1'b0, end_of_frame: 1'b0,
	                 last_of_run: lor_a_s4};
	assign res_b = '{conv_value: total_b, end_of_line: 1'b1, end_of_frame: eof_s4,
	                 last_of_run: 1'b1};

	c3rb_fifo #(
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push_a(ea_s4),
		.data_a(res_a),
		.push_b(eb_s4),
		.data_b(res_b),
		.pop   (pop),
		.valid (m_axis_tvalid),
		.data  (res_out)
	);

	assign m_axis_tdata = res_out.conv_value;
	assign m_axis_tuser = {res_out.end_of_frame, res_out.end_of_line};
	assign m_axis_tlast = res_out.last_of_run;

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_q <= RW'(OUT_DEPTH))
		else $error("result credit count above queue depth");

	a_ram_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && in_acc) |-> (addr_s1 != col_q))
		else $error("line store read and write hit the same column");

	a_eof_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tuser[0] && m_axis_tlast))
		else $error("end of frame without end of line and end of run");

	a_ignored_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && ignore) |=> ($stable(col_q) && $stable(rows_q) && !v_s1))
		else $error("ignored flush changed the frame position");
`endif

endmodule

FILE: hw/rtl/c3rb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3rb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module c3rb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/c3rb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3rb_cell: one window column of the convolver
// Holds a pixel column, passes it to its left neighbour and forms the
// weighted column sums for the current window and the once-more-shifted one.
// ----------------------------------------------------------------------------
module c3rb_cell #(
	parameter int PIXEL_BITS = c3rb_pkg::PIXEL_BITS_DEF
) (
	input  logic                                                  clk,
	input  c3rb_pkg::cell_ctrl_t                                  ctrl,
	input  logic [c3rb_pkg::KERNEL_SIZE-1:0][PIXEL_BITS-1:0]      fill_col,
	input  logic [c3rb_pkg::KERNEL_SIZE-1:0][PIXEL_BITS-1:0]      shift_col,
	input  logic [c3rb_pkg::KERNEL_SIZE-1:0][PIXEL_BITS-1:0]      nb_col,
	input  logic [c3rb_pkg::KERNEL_SIZE-1:0][c3rb_pkg::COEF_BITS-1:0] coef,
	output logic [c3rb_pkg::KERNEL_SIZE-1:0][PIXEL_BITS-1:0]      col,
	output logic [c3rb_pkg::CONV_BITS-1:0]                        sum_a,
	output logic [c3rb_pkg::CONV_BITS-1:0]                        sum_b
);

	import c3rb_pkg::*;

	logic [KERNEL_SIZE-1:0][PIXEL_BITS-1:0] col_q;
	logic signed [CONV_BITS-1:0] prod_a [KERNEL_SIZE];
	logic signed [CONV_BITS-1:0] prod_b [KERNEL_SIZE];
	logic signed [CONV_BITS-1:0] prod_a_s3 [KERNEL_SIZE];
	logic signed [CONV_BITS-1:0] prod_b_s3 [KERNEL_SIZE];
	logic [CONV_BITS-1:0] acc_a;
	logic [CONV_BITS-1:0] acc_b;
	logic [CONV_BITS-1:0] sum_a_s4;
	logic [CONV_BITS-1:0] sum_b_s4;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			col_q <= ctrl.fill ? fill_col : shift_col;
		end
	end

	// products wrap to 32 bits like the sum
	always_comb begin
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			prod_a[r] = CONV_BITS'($signed({1'b0, col_q[r]})) * CONV_BITS'($signed(coef[r]));
			prod_b[r] = CONV_BITS'($signed({1'b0, nb_col[r]})) * CONV_BITS'($signed(coef[r]));
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			prod_a_s3[r] <= prod_a[r];
			prod_b_s3[r] <= prod_b[r];
		end
	end

	always_comb begin
		acc_a = '0;
		acc_b = '0;
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			acc_a = acc_a + prod_a_s3[r];
			acc_b = acc_b + prod_b_s3[r];
		end
	end

	always_ff @(posedge clk) begin
		sum_a_s4 <= acc_a;
		sum_b_s4 <= acc_b;
	end

	assign col   = col_q;
	assign sum_a = sum_a_s4;
	assign sum_b = sum_b_s4;

endmodule

FILE: hw/rtl/c3rb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3rb_fifo: result queue
// Takes up to two results a cycle, hands out one per output transaction.
// ----------------------------------------------------------------------------
module c3rb_fifo #(
	parameter int DEPTH = c3rb_pkg::OUT_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_a,
	input  c3rb_pkg::res_t  data_a,
	input  logic            push_b,
	input  c3rb_pkg::res_t  data_b,
	input  logic            pop,
	output logic            valid,
	output c3rb_pkg::res_t  data
);

	import c3rb_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int NW = AW + 1;

	res_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [NW-1:0] cnt_q;
	logic [AW-1:0] wr_b;

	assign wr_b = wr_q + AW'(push_a);

	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[wr_q] <= data_a;
		end
		if (push_b) begin
			mem_q[wr_b] <= data_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push_a) + AW'(push_b);
			rd_q  <= rd_q + AW'(pop);
			cnt_q <= cnt_q + NW'(push_a) + NW'(push_b) - NW'(pop);
		end
	end

	assign valid = (cnt_q != '0);
	assign data  = mem_q[rd_q];

endmodule

FILE: verif/tb_conv3x3_replicate_border_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv3x3_replicate_border_unit: self-checking bench for the 3x3 convolver
// Streams raster frames and flush ticks under several idle and stall mixes.
// A scoreboard predicts every windowed sum and its row, frame and run marks,
// and compares each output transaction in order against that prediction.
// ----------------------------------------------------------------------------
module tb_conv3x3_replicate_border_unit;
	import c3rb_pkg::*;

	localparam int MAX_W       = MAX_WIDTH_DEF;
	localparam int PIX_W       = ((PIXEL_BITS_DEF + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 12;
	localparam int PHASE_ITEMS = 180;

	class conv_scoreboard;
		logic [KROW_BITS-1:0] krow [KERNEL_SIZE];
		logic [LW_BITS-1:0]   width_reg;
		logic [7:0]           upper_line [MAX_W];
		logic [7:0]           middle_line [MAX_W];
		logic [7:0]           win [KERNEL_SIZE][KERNEL_SIZE];  // [column][row]
		int unsigned          col;
		int unsigned          rows_done;
		bit                   flush_mode;
		res_t                 sums_due [$];
		int                   errors;
		int                   items_taken;
		int                   results_seen;
		int                   frames_done;

		function new();
			foreach (krow[i])
				krow[i] = '0;
			foreach (win[i, j])
				win[i][j] = '0;
			width_reg = LW_BITS'(LW_RESET);
		endfunction

		function void set_reg(cfg_idx_t idx, logic [KROW_BITS-1:0] d);
			case (idx)
				CFG_KROW0: krow[0] = d;
				CFG_KROW1: krow[1] = d;
				CFG_KROW2: krow[2] = d;
				CFG_LWIDTH: width_reg = d[LW_BITS-1:0];
			endcase
		endfunction

		function int unsigned eff_width();
			if (width_reg < 2)
				return 2;
			if (width_reg > MAX_W)
				return MAX_W;
			return width_reg;
		endfunction

		function logic [CONV_BITS-1:0] window_sum();
			int acc, k;
			acc = 0;
			for (int r = 0; r < KERNEL_SIZE; r++)
				for (int c = 0; c < KERNEL_SIZE; c++) begin
					k = $signed(krow[r][c*COEF_BITS +: COEF_BITS]);
					acc += k * int'(win[c][r]);
				end
			return acc;
		endfunction

		function void shift_window();
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				win[0][r] = win[1][r];
				win[1][r] = win[2][r];
			end
		endfunction

		function void load_column(int c, logic [7:0] up, logic [7:0] mid, logic [7:0] bot);
			win[c][0] = up;
			win[c][1] = mid;
			win[c][2] = bot;
		endfunction

		function void note_sum(bit eol, bit eof, bit lor);
			res_t r;
			r.conv_value   = window_sum();
			r.end_of_line  = eol;
			r.end_of_frame = eof;
			r.last_of_run  = lor;
			sums_due.push_back(r);
		endfunction

		function void note_input(logic req, logic [7:0] pix);
			int unsigned w, c, idx;
			bit flush, is_last;
			logic [7:0] up, mid, bot;
			items_taken++;
			w = eff_width();
			c = col;
			flush = req || flush_mode;
			// flush ticks before a whole row are dropped
			if (flush && rows_done == 0)
				return;
			is_last = (c >= w - 1);
			idx = (c < MAX_W) ? c : MAX_W - 1;
			if (rows_done == 0) begin
				upper_line[idx] = pix;
				middle_line[idx] = pix;
				if (is_last) begin
					col = 0;
					rows_done = 1;
				end else begin
					col = c + 1;
				end
				return;
			end
			up = upper_line[idx];
			mid = middle_line[idx];
			if (flush) begin
				flush_mode = 1'b1;
				bot = mid;
			end else begin
				bot = pix;
				upper_line[idx] = mid;
				middle_line[idx] = pix;
			end
			if (c == 0) begin
				for (int i = 0; i < KERNEL_SIZE; i++)
					load_column(i, up, mid, bot);
			end else begin
				shift_window();
				load_column(2, up, mid, bot);
				note_sum(1'b0, 1'b0, !is_last);
			end
			if (is_last) begin
				shift_window();
				note_sum(1'b1, flush_mode, 1'b1);
				col = 0;
				if (flush_mode) begin
					rows_done = 0;
					flush_mode = 1'b0;
					frames_done++;
				end else if (rows_done < 2) begin
					rows_done++;
				end
			end else begin
				col = c + 1;
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 30)
				$display("ERROR @%0t: %s", $realtime, msg);
		endtask

		task check_result(logic [CONV_BITS-1:0] data, logic eol, logic eof, logic lor);
			res_t e;
			results_seen++;
			if (sums_due.size() == 0) begin
				report($sformatf("unexpected result %0d", $signed(data)));
				return;
			end
			e = sums_due.pop_front();
			if (data !== e.conv_value)
				report($sformatf("conv_value %0d, expected %0d", $signed(data),
					$signed(e.conv_value)));
			if (eol !== e.end_of_line)
				report($sformatf("end_of_line %b, expected %b", eol, e.end_of_line));
			if (eof !== e.end_of_frame)
				report($sformatf("end_of_frame %b, expected %b", eof, e.end_of_frame));
			if (lor !== e.last_of_run)
				report($sformatf("last_of_run %b, expected %b", lor, e.last_of_run));
		endtask
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [PIX_W-1:0]          s_axis_tdata = '0;   // pixel_value
	logic [0:0]                s_axis_tuser = '0;   // req_type
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [CONV_BITS-1:0]      m_axis_tdata;        // conv_value
	logic [1:0]                m_axis_tuser;        // end_of_line, end_of_frame
	logic                      m_axis_tlast;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]   cfg_index = CFG_KROW0;
	logic [KROW_BITS-1:0]      cfg_data = '0;

	conv_scoreboard sb = new();
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_left = 0;
	int cycles = 0;

	conv3x3_replicate_border_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: long hold-off first, then random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] rand_pixel();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [KROW_BITS-1:0] rand_krow();
		logic [KROW_BITS-1:0] v;
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			case ($urandom_range(5))
				0: v[i*COEF_BITS +: COEF_BITS] = 16'h7FFF;
				1: v[i*COEF_BITS +: COEF_BITS] = 16'h8000;
				2: v[i*COEF_BITS +: COEF_BITS] = 16'hFFFF;
				default: v[i*COEF_BITS +: COEF_BITS] = COEF_BITS'($urandom);
			endcase
		end
		return v;
	endfunction

	// called and returns at a falling edge; tvalid stays high for back-to-back
	task automatic send_item(logic req, logic [7:0] pix);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= PIX_W'(pix);
		s_axis_tuser <= req;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_input(req, pix);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.sums_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [KROW_BITS-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, d);
	endtask

	task automatic send_row(int n);
		repeat (n) send_item(1'b0, rand_pixel());
	endtask

	// first tick marked as flush, later ones may be plain pixels
	task automatic flush_frame(output int ticks);
		ticks = 0;
		while (sb.rows_done != 0) begin
			send_item(sb.flush_mode ? 1'($urandom_range(1)) : 1'b1, rand_pixel());
			ticks++;
		end
	endtask

	task automatic run_frame(output int items);
		int w, rows, part, ticks;
		w = sb.eff_width();
		if ($urandom_range(9) == 0)
			send_item(1'b1, rand_pixel());
		rows = $urandom_range(1, 4);
		for (int r = 0; r < rows; r++) begin
			send_row(w);
			if ($urandom_range(24) == 0)
				drain();
		end
		items = rows * w;
		if ($urandom_range(4) == 0) begin
			part = $urandom_range(1, w - 1);
			send_row(part);
			items += part;
		end
		flush_frame(ticks);
		items += ticks;
	endtask

	int idle_mix  [4] = '{0, 82, 0, 27};
	int stall_mix [4] = '{0, 0, 82, 27};

	initial begin
		int n, got;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// coefficient extremes, width below range
		write_reg(CFG_KROW0, {16'h0001, 16'h7FFF, 16'h8000});
		write_reg(CFG_KROW1, {16'hFFFF, 16'h0002, 16'h8000});
		write_reg(CFG_KROW2, {KROW_BITS{1'b1}});
		write_reg(CFG_LWIDTH, '0);
		send_item(1'b1, 8'hFF);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hFF);
		drain();
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'h00);
		send_item(1'b1, 8'h5A);
		drain();

		// flush inside the first row, then plain pixels while flushing
		write_reg(CFG_LWIDTH, KROW_BITS'(5));
		send_row(2);
		send_item(1'b1, 8'hA5);
		send_row(3);
		send_item(1'b1, 8'h00);
		repeat (4) send_item(1'b0, rand_pixel());
		drain();

		// width narrowed part way through a row
		send_row(5);
		send_row(3);
		drain();
		write_reg(CFG_LWIDTH, KROW_BITS'(1));
		send_item(1'b0, 8'hFF);
		flush_frame(got);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			src_idle_pct = idle_mix[ph / 2];
			sink_stall_pct = stall_mix[ph / 2];
			write_reg(CFG_KROW0, rand_krow());
			write_reg(CFG_KROW1, rand_krow());
			write_reg(CFG_KROW2, rand_krow());
			write_reg(CFG_LWIDTH, KROW_BITS'((ph % 2) ? $urandom_range(13, 40) :
				$urandom_range(2, 12)));
			if (ph == 0)
				hold_left = 400;
			n = 0;
			while (n < PHASE_ITEMS) begin
				run_frame(got);
				n += got;
			end
			drain();
		end

		// widest line, width register above range
		src_idle_pct = 0;
		sink_stall_pct = 0;
		write_reg(CFG_KROW0, rand_krow());
		write_reg(CFG_KROW1, rand_krow());
		write_reg(CFG_KROW2, rand_krow());
		write_reg(CFG_LWIDTH, KROW_BITS'(11'h7FF));
		send_row(sb.eff_width());
		flush_frame(got);
		drain();

		if (sb.sums_due.size() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.sums_due.size()));
		$display("covered %0d input transactions over %0d frames, %0d results checked",
			sb.items_taken, sb.frames_done, sb.results_seen);
		$display("widths 2..40 plus clamped 0, 1 and 2047; kernel extremes; four idle mixes");
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/c3rb_pkg.sv
hw/rtl/c3rb_ram.sv
hw/rtl/c3rb_cell.sv
hw/rtl/c3rb_fifo.sv
hw/rtl/conv3x3_replicate_border_unit.sv
verif/tb_conv3x3_replicate_border_unit.sv
